@@ rtl/dtx_pkg.sv @@
// ----------------------------------------------------------------------------
// dtx_pkg: shared types and constants for the decimal text converter
// Character codes, the reciprocal used for divide-by-ten and the work item
// that travels down the digit pipeline.
// ----------------------------------------------------------------------------
package dtx_pkg;

   // ASCII codes, cut to the 6-bit result field
   localparam logic [5:0] CHAR_ZERO  = 6'd48;
   localparam logic [5:0] CHAR_MINUS = 6'd45;
   localparam logic [5:0] CHAR_SPACE = 6'd32;

   // x / 10 == (x * 52429) >> 19 for every 16-bit unsigned x
   localparam logic [15:0] RECIP_TEN   = 16'd52429;
   localparam int          RECIP_SHIFT = 19;
   localparam logic [3:0]  RADIX       = 4'd10;

   // Number of digit stages; the leading digit is what is left after them
   localparam int DIGIT_STAGES = 4;

   typedef logic [3:0] digit_type;

   // Work item: sign, total length, remaining magnitude, digits so far
   typedef struct packed {
      logic                               negative;
      logic [2:0]                         text_length;
      logic [15:0]                        value;
      logic [DIGIT_STAGES-1:0][3:0]       digits;
   } work_type;

endpackage

@@ rtl/dtx_chan_if.sv @@
// ----------------------------------------------------------------------------
// dtx_req_if / dtx_rsp_if: request and response channels
// Valid/ready channels; a transaction completes when both are high.
// ----------------------------------------------------------------------------
interface dtx_req_if;
   logic               valid;
   logic               ready;
   logic signed [15:0] value;

   modport source (output valid, output value, input ready);
   modport sink   (input valid, input value, output ready);
endinterface

interface dtx_rsp_if;
   logic       valid;
   logic       ready;
   logic [5:0] char_code;
   logic       last;
   logic [2:0] text_length;

   modport source (output valid, output char_code, output last, output text_length,
                   input ready);
   modport sink   (input valid, input char_code, input last, input text_length,
                   output ready);
endinterface

@@ rtl/signed_int_to_decimal_text.sv @@
// ----------------------------------------------------------------------------
// signed_int_to_decimal_text: 16-bit signed integer to ASCII decimal text
// A number accepted on the request channel leaves the response channel as
// a sign character ('-' or space) followed by its digits, most significant
// first, with no leading zeros; each character carries the total length and
// the final one is flagged. A number of n digits takes n+1 response
// transactions (2 to 6), sent by the single-character output stage; the
// magnitude, length and four divide-by-ten stages run as a stalling pipeline
// in front of it, so a request passes the front register and the four
// digit-stage registers before the output stage loads it, and later numbers
// follow back to back once the pipeline is full.
// ----------------------------------------------------------------------------
module signed_int_to_decimal_text (
   input  logic      clock,
   input  logic      reset,
   dtx_req_if.sink   req_chan,
   dtx_rsp_if.source rsp_chan
);

   localparam int NS = dtx_pkg::DIGIT_STAGES;

   logic              front_valid_ff, front_valid_in;
   dtx_pkg::work_type front_work_ff, front_work_in;

   logic [15:0] magnitude;
   logic [2:0]  length;

   logic              pipe_valid [NS+1];
   logic              pipe_ready [NS+1];
   dtx_pkg::work_type pipe_work  [NS+1];

   // Magnitude (unsigned, so -32768 gives 32768) and text length (digits plus sign)
   always_comb begin
      magnitude = req_chan.value[15] ? (16'd0 - req_chan.value) : req_chan.value;
      if (magnitude >= 16'd10000) begin
         length = 3'd6;
      end else if (magnitude >= 16'd1000) begin
         length = 3'd5;
      end else if (magnitude >= 16'd100) begin
         length = 3'd4;
      end else if (magnitude >= 16'd10) begin
         length = 3'd3;
      end else begin
         length = 3'd2;
      end
   end

   assign req_chan.ready = !front_valid_ff || pipe_ready[0];

   // Front stage register
   always_comb begin
      front_valid_in = front_valid_ff;
      front_work_in  = front_work_ff;
      if (req_chan.ready) begin
         front_valid_in            = req_chan.valid;
         front_work_in.negative    = req_chan.value[15];
         front_work_in.text_length = length;
         front_work_in.value       = magnitude;
         front_work_in.digits      = '0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         front_valid_ff <= 1'b0;
      end else begin
         front_valid_ff <= front_valid_in;
      end
      front_work_ff <= front_work_in;
   end

   assign pipe_valid[0] = front_valid_ff;
   assign pipe_work[0]  = front_work_ff;

   // Divide-by-ten stages
   for (genvar g = 0; g < NS; g++) begin : g_digit
      dtx_digit_stage u_stage (
         .clock     (clock),
         .reset     (reset),
         .in_valid  (pipe_valid[g]),
         .in_ready  (pipe_ready[g]),
         .in_work   (pipe_work[g]),
         .out_valid (pipe_valid[g+1]),
         .out_ready (pipe_ready[g+1]),
         .out_work  (pipe_work[g+1])
      );
   end

   // Character output
   dtx_serialiser u_serialiser (
      .clock    (clock),
      .reset    (reset),
      .in_valid (pipe_valid[NS]),
      .in_ready (pipe_ready[NS]),
      .in_work  (pipe_work[NS]),
      .rsp_chan (rsp_chan)
   );

endmodule

@@ rtl/dtx_digit_stage.sv @@
// ----------------------------------------------------------------------------
// dtx_digit_stage: one divide-by-ten pipeline stage
// Splits the lowest decimal digit off the remaining magnitude and shifts it
// into the digit field. Stalls hold the stage contents.
// ----------------------------------------------------------------------------
module dtx_digit_stage (
   input  logic              clock,
   input  logic              reset,
   input  logic              in_valid,
   output logic              in_ready,
   input  dtx_pkg::work_type in_work,
   output logic              out_valid,
   input  logic              out_ready,
   output dtx_pkg::work_type out_work
);

   logic              valid_ff, valid_in;
   dtx_pkg::work_type work_ff, work_in;

   logic [31:0] product;
   logic [15:0] quotient;
   logic [15:0] remainder;

   // Quotient by reciprocal multiply, remainder by shift-and-subtract
   always_comb begin
      product   = 32'(in_work.value) * 32'(dtx_pkg::RECIP_TEN);
      quotient  = 16'(product >> dtx_pkg::RECIP_SHIFT);
      remainder = in_work.value - {quotient[12:0], 3'b000} - {quotient[14:0], 1'b0};
   end

   assign in_ready = !valid_ff || out_ready;

   // Stage register
   always_comb begin
      valid_in = valid_ff;
      work_in  = work_ff;
      if (in_ready) begin
         valid_in            = in_valid;
         work_in             = in_work;
         work_in.value       = quotient;
         work_in.digits      = {in_work.digits[dtx_pkg::DIGIT_STAGES-2:0], remainder[3:0]};
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
      work_ff <= work_in;
   end

   assign out_valid = valid_ff;
   assign out_work  = work_ff;

`ifndef NO_ASSERTIONS
   // The newest digit is a decimal digit
   a_digit_range: assert property (@(posedge clock) disable iff (reset)
      valid_ff |-> (work_ff.digits[0] < dtx_pkg::RADIX))
      else $error("digit stage produced a digit above nine");
`endif

endmodule

@@ rtl/dtx_serialiser.sv @@
// ----------------------------------------------------------------------------
// dtx_serialiser: character output stage
// Holds one converted number and sends its sign and digits, one character
// per response transaction, most significant digit first.
// ----------------------------------------------------------------------------
module dtx_serialiser (
   input  logic              clock,
   input  logic              reset,
   input  logic              in_valid,
   output logic              in_ready,
   input  dtx_pkg::work_type in_work,
   dtx_rsp_if.source         rsp_chan
);

   logic       busy_ff, busy_in;
   logic [2:0] pos_ff, pos_in;
   logic [2:0] idx_ff, idx_in;
   logic       neg_ff, neg_in;
   logic [2:0] len_ff, len_in;
   dtx_pkg::digit_type ms_ff [5];
   dtx_pkg::digit_type ms_in [5];

   logic last_char;
   logic load;
   logic take;

   assign last_char = (pos_ff == (len_ff - 3'd1));
   assign take      = busy_ff && rsp_chan.ready;
   assign in_ready  = !busy_ff || (rsp_chan.ready && last_char);
   assign load      = in_valid && in_ready;

   // Sequencing: sign first, then digits from the first significant one
   always_comb begin
      busy_in = busy_ff;
      pos_in  = pos_ff;
      idx_in  = idx_ff;
      neg_in  = neg_ff;
      len_in  = len_ff;
      ms_in   = ms_ff;
      if (load) begin
         busy_in  = 1'b1;
         pos_in   = 3'd0;
         idx_in   = 3'd6 - in_work.text_length;
         neg_in   = in_work.negative;
         len_in   = in_work.text_length;
         ms_in[0] = in_work.value[3:0];
         ms_in[1] = in_work.digits[0];
         ms_in[2] = in_work.digits[1];
         ms_in[3] = in_work.digits[2];
         ms_in[4] = in_work.digits[3];
      end else if (take) begin
         if (last_char) begin
            busy_in = 1'b0;
         end else begin
            pos_in = pos_ff + 3'd1;
            if (pos_ff != 3'd0) begin
               idx_in = idx_ff + 3'd1;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         pos_ff  <= 3'd0;
         idx_ff  <= 3'd0;
      end else begin
         busy_ff <= busy_in;
         pos_ff  <= pos_in;
         idx_ff  <= idx_in;
      end
      neg_ff <= neg_in;
      len_ff <= len_in;
      ms_ff  <= ms_in;
   end

   // Response payload
   always_comb begin
      rsp_chan.valid       = busy_ff;
      rsp_chan.last        = last_char;
      rsp_chan.text_length = len_ff;
      if (pos_ff == 3'd0) begin
         rsp_chan.char_code = neg_ff ? dtx_pkg::CHAR_MINUS : dtx_pkg::CHAR_SPACE;
      end else begin
         rsp_chan.char_code = dtx_pkg::CHAR_ZERO + {2'b00, ms_ff[idx_ff]};
      end
   end

`ifndef NO_ASSERTIONS
   // Character position never runs past the stored length
   a_pos_bound: assert property (@(posedge clock) disable iff (reset)
      busy_ff |-> (pos_ff < len_ff))
      else $error("character position beyond text length");

   // Stored length is always a legal text length
   a_len_range: assert property (@(posedge clock) disable iff (reset)
      busy_ff |-> (len_ff >= 3'd2 && len_ff <= 3'd6))
      else $error("text length out of range");

   // Digit pointer stays inside the digit store
   a_idx_bound: assert property (@(posedge clock) disable iff (reset)
      (busy_ff && pos_ff != 3'd0) |-> (idx_ff <= 3'd4))
      else $error("digit pointer outside the digit store");

   // After the last character is taken without a new number, output goes idle
   a_idle_after_last: assert property (@(posedge clock) disable iff (reset)
      (take && last_char && !in_valid) |=> !busy_ff)
      else $error("output stayed busy after last character");
`endif

endmodule

@@ bench/signed_int_to_decimal_text_tb.sv @@
// ----------------------------------------------------------------------------
// signed_int_to_decimal_text_tb: self-checking bench for the decimal text
// converter
// Every accepted number is spelt out as its expected characters: the sign
// position, then the digits with no leading zeros. Response transactions are
// checked in order against them. Directed extremes come first, then random
// numbers of every digit count. Both channels idle at random. A long response
// hold fills the pipeline, and the sender pauses until the bench drains.
// ----------------------------------------------------------------------------

// One expected character of a number's text
typedef struct packed {
   logic [5:0] char_code;
   logic       last;
   logic [2:0] text_length;
} text_char_type;

// Predicts the text of each accepted number and checks characters against it
class decimal_text_checker;
   text_char_type pending_chars[$];
   int            errors;
   int            numbers;
   int            negatives;
   int            chars_checked;

   function new();
      errors        = 0;
      numbers       = 0;
      negatives     = 0;
      chars_checked = 0;
   endfunction

   function int pending();
      return pending_chars.size();
   endfunction

   // Spell out one accepted number, sign position first
   function void note_value(logic [15:0] raw);
      logic          negative;
      logic [15:0]   magnitude;
      logic [3:0]    digit_seq [5];
      int            ndigits;
      text_char_type ch;
      negative  = raw[15];
      // -32768 wraps back to 0x8000, read unsigned as 32768
      magnitude = negative ? (~raw + 16'd1) : raw;
      ndigits   = 0;
      do begin
         digit_seq[ndigits] = 4'(magnitude % 16'd10);
         magnitude          = magnitude / 16'd10;
         ndigits++;
      end while (magnitude != 16'd0 && ndigits < 5);
      ch.text_length = 3'(ndigits + 1);
      ch.char_code   = negative ? dtx_pkg::CHAR_MINUS : dtx_pkg::CHAR_SPACE;
      ch.last        = 1'b0;
      pending_chars.push_back(ch);
      // digits leave most significant first
      for (int k = ndigits - 1; k >= 0; k--) begin
         ch.char_code = dtx_pkg::CHAR_ZERO + 6'(digit_seq[k]);
         ch.last      = (k == 0);
         pending_chars.push_back(ch);
      end
      numbers++;
      if (negative) negatives++;
   endfunction

   // Compare one response transaction with the oldest expected character
   function void check_char(text_char_type got);
      text_char_type want;
      chars_checked++;
      if (pending_chars.size() == 0) begin
         errors++;
         $display("%0t: unexpected character: expected none, got code %0d last %0b length %0d",
                  $time, got.char_code, got.last, got.text_length);
         return;
      end
      want = pending_chars.pop_front();
      if (got.char_code !== want.char_code) begin
         errors++;
         $display("%0t: char_code mismatch: expected %0d, got %0d",
                  $time, want.char_code, got.char_code);
      end
      if (got.last !== want.last) begin
         errors++;
         $display("%0t: last mismatch: expected %0b, got %0b", $time, want.last, got.last);
      end
      if (got.text_length !== want.text_length) begin
         errors++;
         $display("%0t: text_length mismatch: expected %0d, got %0d",
                  $time, want.text_length, got.text_length);
      end
   endfunction
endclass

module signed_int_to_decimal_text_tb;

   localparam int CYCLE_LIMIT  = 100000;
   localparam int HOLD_CYCLES  = 300;
   localparam int IDLE_PERCENT = 12;
   localparam int SETTLE       = 20;

   logic clock = 1'b0;
   logic reset;

   dtx_req_if req_chan ();
   dtx_rsp_if rsp_chan ();

   signed_int_to_decimal_text dut (
      .clock    (clock),
      .reset    (reset),
      .req_chan (req_chan),
      .rsp_chan (rsp_chan)
   );

   decimal_text_checker checker_h = new();

   bit send_gaps;
   bit rsp_idle;
   bit hold_go;
   bit hold_ack;
   int hold_left;
   int cycle_count;
   int items_sent;

   // Clock
   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // Run limit
   initial begin
      cycle_count = 0;
      while (cycle_count < CYCLE_LIMIT) begin
         @(posedge clock);
         cycle_count++;
      end
      $display("%0t: timeout after %0d cycles", $time, cycle_count);
      $display("DONE: errors detected");
      $finish;
   end

   // Receiver: random back-pressure, plus a long hold when asked
   initial begin
      rsp_chan.ready <= 1'b0;
      hold_left = 0;
      hold_ack  = 1'b0;
      forever begin
         @(posedge clock);
         if (reset) begin
            rsp_chan.ready <= 1'b0;
         end else if (hold_left != 0) begin
            rsp_chan.ready <= 1'b0;
            hold_left--;
         end else if (hold_go != hold_ack) begin
            hold_ack = hold_go;
            hold_left = HOLD_CYCLES - 1;
            rsp_chan.ready <= 1'b0;
         end else begin
            rsp_chan.ready <= rsp_idle ? ($urandom_range(99) >= IDLE_PERCENT) : 1'b1;
         end
      end
   end

   // Monitor both channels; values are those from before the edge
   always @(posedge clock) begin
      if (!reset) begin
         if (req_chan.valid && req_chan.ready)
            checker_h.note_value(req_chan.value);
         if (rsp_chan.valid && rsp_chan.ready)
            checker_h.check_char({rsp_chan.char_code, rsp_chan.last, rsp_chan.text_length});
      end
   end

   // Offer one number and wait for its transaction; called and left at an edge
   task automatic send_value(input logic [15:0] raw);
      int gap;
      if (send_gaps && $urandom_range(99) < IDLE_PERCENT) begin
         gap = $urandom_range(1, 4);
         req_chan.valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_chan.valid <= 1'b1;
      req_chan.value <= raw;
      do @(posedge clock); while (!req_chan.ready);
      items_sent++;
   endtask

   // Stop offering and wait until every expected character has arrived
   task automatic drain();
      req_chan.valid <= 1'b0;
      do @(posedge clock); while (checker_h.pending() != 0);
   endtask

   // Random number with a chosen digit count, or a raw 16-bit pattern
   function automatic logic [15:0] random_value();
      int          ndigits;
      int          lo;
      int          hi;
      int          magnitude;
      bit          negative;
      if ($urandom_range(5) == 0)
         return 16'($urandom);
      ndigits  = $urandom_range(1, 5);
      negative = $urandom_range(1);
      lo = 1;
      repeat (ndigits - 1) lo = lo * 10;
      hi = lo * 10 - 1;
      if (ndigits == 1) lo = 0;
      if (ndigits == 5) hi = negative ? 32768 : 32767;
      magnitude = $urandom_range(hi, lo);
      return negative ? 16'(-magnitude) : 16'(magnitude);
   endfunction

   // Stimulus
   initial begin
      logic [15:0] directed_values [$];
      reset          <= 1'b1;
      req_chan.valid <= 1'b0;
      req_chan.value <= '0;
      send_gaps  = 1'b0;
      rsp_idle   = 1'b0;
      hold_go    = 1'b0;
      items_sent = 0;
      repeat (10) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Directed: zero, digit-count boundaries, both extremes, bit patterns
      directed_values = '{16'd0, 16'd1, 16'hFFFF, 16'd9, 16'd10, -16'sd10, 16'd99,
                          16'd100, -16'sd999, 16'd1000, 16'd9999, -16'sd10000,
                          16'd32767, 16'h8000, 16'h8001, -16'sd9, 16'd12345,
                          -16'sd12345, 16'h5555, 16'hAAAA, 16'd10000};
      foreach (directed_values[i]) send_value(directed_values[i]);
      drain();

      // Random with idling on both sides
      send_gaps = 1'b1;
      rsp_idle  = 1'b1;
      repeat (80) send_value(random_value());

      // Long stretch with no idling
      send_gaps = 1'b0;
      rsp_idle  = 1'b0;
      repeat (60) send_value(random_value());

      // Receiver holds off while numbers keep coming, so the input stalls
      hold_go <= ~hold_go;
      repeat (25) send_value(random_value());

      // Sender pauses until all characters are out
      drain();

      send_gaps = 1'b1;
      rsp_idle  = 1'b1;
      repeat (85) send_value(random_value());

      drain();
      repeat (SETTLE) @(posedge clock);

      $display("Converted %0d numbers (%0d negative), %0d characters checked.",
               checker_h.numbers, checker_h.negatives, checker_h.chars_checked);
      $display("Covered extremes, every digit count, random idling and a long output hold.");
      if (checker_h.errors == 0 && checker_h.pending() == 0)
         $display("DONE: 0 errors");
      else
         $display("DONE: errors detected");
      $finish;
   end

endmodule

@@ files.f @@
rtl/dtx_pkg.sv
rtl/dtx_chan_if.sv
rtl/dtx_digit_stage.sv
rtl/dtx_serialiser.sv
rtl/signed_int_to_decimal_text.sv
bench/signed_int_to_decimal_text_tb.sv
